>>> hdl/vde_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package vde_pkg;
	localparam int unsigned MAX_LEN_DEF = 1024;
	localparam int unsigned DIST_W = 60;

	typedef enum logic [2:0] {
		MET_EUCLID = 3'd0,
		MET_EUCLID_SQ = 3'd1,
		MET_MANHATTAN = 3'd2,
		MET_CHEBYSHEV = 3'd3,
		MET_COSINE = 3'd4,
		MET_BRAY = 3'd5,
		MET_CANBERRA = 3'd6,
		MET_UNUSED = 3'd7
	} metric_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_ZERO_DIV = 2'd1,
		ST_TOO_LONG = 2'd2,
		ST_RSVD = 2'd3
	} status_t;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	// One classified pair, as handed from the front end to the back end.
	typedef struct packed {
		logic        skip;
		metric_t     metric;
		logic [16:0] ad;
		logic [16:0] aa;
		logic [16:0] ab;
		logic [16:0] as_;
		logic signed [15:0] a;
		logic signed [15:0] b;
		logic        last;
	} pair_t;
endpackage
`default_nettype wire

>>> hdl/vde_front.sv
`timescale 1ns / 1ps
`default_nettype none
module vde_front #(
	parameter int unsigned MAX_LEN = vde_pkg::MAX_LEN_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  wire signed [15:0]   elem_a,
	input  wire signed [15:0]   elem_b,
	input  wire                 last_pair,
	input  vde_pkg::metric_t    metric,
	output logic                q_valid,
	input  wire                 q_stall,
	output vde_pkg::pair_t      q_data
);
	import vde_pkg::*;
	localparam int CW = $clog2(MAX_LEN + 1);

	logic [CW-1:0] count_q;
	logic          acc;
	logic signed [16:0] d, s;
	logic [16:0] ad, aa, ab;

	always_comb begin
		d = 17'(elem_a) - 17'(elem_b);
		s = 17'(elem_a) + 17'(elem_b);
		ad = d[16] ? 17'(-d) : d;
		aa = elem_a[15] ? 17'(-17'(elem_a)) : 17'(elem_a);
		ab = elem_b[15] ? 17'(-17'(elem_b)) : 17'(elem_b);
	end

	assign in_stall = q_valid && q_stall;
	assign acc = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			q_valid <= 1'b0;
		end else begin
			if (acc) begin
				q_valid <= 1'b1;
				if (last_pair) count_q <= '0;
				else if (count_q < CW'(MAX_LEN)) count_q <= count_q + 1'b1;
				else count_q <= count_q;
			end else if (!q_stall) begin
				q_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			q_data.skip <= (count_q >= CW'(MAX_LEN));
			q_data.metric <= metric;
			q_data.ad <= ad;
			q_data.aa <= aa;
			q_data.ab <= ab;
			q_data.as_ <= s[16] ? 17'(-s) : s;
			q_data.a <= elem_a;
			q_data.b <= elem_b;
			q_data.last <= last_pair;
		end
	end
endmodule
`default_nettype wire

>>> hdl/vde_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module vde_fifo (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_stall,
	input  vde_pkg::pair_t   in_data,
	output logic             out_valid,
	input  wire              out_stall,
	output vde_pkg::pair_t   out_data
);
	import vde_pkg::*;
	pair_t mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic wr, rd;

	assign in_stall = (cnt_q == 3'd4);
	assign out_valid = (cnt_q != 3'd0);
	assign out_data = mem_q[rp_q];
	assign wr = in_valid && !in_stall;
	assign rd = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + 3'(wr) - 3'(rd);
		end
	end
endmodule
`default_nettype wire

>>> hdl/vde_back.sv
`timescale 1ns / 1ps
`default_nettype none
module vde_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  vde_pkg::pair_t      in_data,
	output logic                out_valid,
	input  wire                 out_stall,
	output logic [59:0]         distance,
	output logic [1:0]          status
);
	import vde_pkg::*;

	typedef enum logic [9:0] {
		S_ACC    = 10'b0000000001,
		S_CDIV   = 10'b0000000010,
		S_FIN    = 10'b0000000100,
		S_RTA    = 10'b0000001000,
		S_RTB    = 10'b0000010000,
		S_MUL    = 10'b0000100000,
		S_COS    = 10'b0001000000,
		S_DIV    = 10'b0010000000,
		S_DIVEND = 10'b0100000000,
		S_OUT    = 10'b1000000000
	} state_t;

	state_t state_q;
	logic signed [45:0] main_q;
	logic [40:0] na_q, nb_q;
	logic [16:0] largest_q;
	logic ovf_q;
	pair_t cur_q;

	// Shared restoring divider, and the square-root engine.
	logic [63:0] n_q;
	logic [47:0] dv_q;
	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [6:0] it_q;
	logic [31:0] ra_q;
	logic [47:0] den_q;
	logic [95:0] rt_v_q;
	logic [63:0] rt_r_q, rt_rem_q;
	logic [2:0] div_kind_q; // not a code; which finish to apply
	logic [59:0] dist_q;
	logic [1:0] st_q;
	logic acc;
	logic signed [31:0] prod, sq_a, sq_b;
	logic [63:0] rt_t, rt_rem_n, div_rem_n;

	assign in_stall = (state_q != S_ACC) || (out_valid && out_stall);
	assign acc = in_valid && !in_stall;
	assign prod = in_data.a * in_data.b;
	assign sq_a = in_data.a * in_data.a;
	assign sq_b = in_data.b * in_data.b;
	assign distance = dist_q;
	assign status = st_q;

	always_comb begin
		rt_rem_n = {rt_rem_q[61:0], rt_v_q[95:94]};
		rt_t = {rt_r_q[61:0], 2'b01};
		div_rem_n = {rem_q[62:0], n_q[63]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_ACC;
			main_q <= '0;
			na_q <= '0;
			nb_q <= '0;
			largest_q <= '0;
			ovf_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (state_q)
				S_ACC: begin
					if (acc) begin
						cur_q <= in_data;
						if (in_data.skip) ovf_q <= 1'b1;
						else begin
							unique case (in_data.metric)
								MET_EUCLID, MET_EUCLID_SQ:
									main_q <= main_q +
										46'(34'(in_data.ad) * 34'(in_data.ad));
								MET_MANHATTAN: main_q <= main_q + 46'(in_data.ad);
								MET_CHEBYSHEV:
									if (in_data.ad > largest_q) largest_q <= in_data.ad;
								MET_COSINE: begin
									main_q <= main_q + 46'(prod);
									na_q <= na_q + 41'(sq_a);
									nb_q <= nb_q + 41'(sq_b);
								end
								MET_BRAY: begin
									main_q <= main_q + 46'(in_data.ad);
									na_q <= na_q + 41'(in_data.as_);
								end
								MET_CANBERRA: ;
								default: ;
							endcase
						end
						if (!in_data.skip && in_data.metric == MET_CANBERRA &&
							(in_data.aa + in_data.ab) != 17'd0) begin
							n_q <= {31'd0, in_data.ad, 16'd0};
							dv_q <= 48'(in_data.aa + in_data.ab);
							rem_q <= '0;
							quo_q <= '0;
							it_q <= 7'd64;
							state_q <= S_CDIV;
						end else if (in_data.last) state_q <= S_FIN;
					end
				end
				S_CDIV: begin
					// One quotient bit per cycle.
					n_q <= {n_q[62:0], 1'b0};
					if (div_rem_n >= 64'(dv_q)) begin
						rem_q <= div_rem_n - 64'(dv_q);
						quo_q <= {quo_q[62:0], 1'b1};
					end else begin
						rem_q <= div_rem_n;
						quo_q <= {quo_q[62:0], 1'b0};
					end
					it_q <= it_q - 1'b1;
					if (it_q == 7'd1) begin
						main_q <= main_q + 46'({quo_q[33:0], div_rem_n >= 64'(dv_q)});
						state_q <= cur_q.last ? S_FIN : S_ACC;
					end
				end
				S_FIN: begin
					st_q <= ST_OK;
					dist_q <= '0;
					state_q <= S_OUT;
					if (ovf_q) st_q <= ST_TOO_LONG;
					else begin
						unique case (cur_q.metric)
							MET_EUCLID: begin
								rt_v_q <= {64'(main_q), 32'd0};
								rt_r_q <= '0;
								rt_rem_q <= '0;
								it_q <= 7'd48;
								div_kind_q <= 3'd0;
								state_q <= S_RTA;
							end
							MET_EUCLID_SQ, MET_MANHATTAN:
								dist_q <= (main_q[45:44] != 2'b00) ? DIST_MAX :
									{main_q[43:0], 16'd0};
							MET_CHEBYSHEV: dist_q <= {27'd0, largest_q, 16'd0};
							MET_COSINE: begin
								rt_v_q <= {23'd0, na_q, 32'd0};
								rt_r_q <= '0;
								rt_rem_q <= '0;
								it_q <= 7'd32;
								div_kind_q <= 3'd1;
								state_q <= S_RTA;
							end
							MET_BRAY: begin
								if (na_q == '0) st_q <= ST_ZERO_DIV;
								else begin
									n_q <= 64'(main_q);
									dv_q <= 48'(na_q);
									rem_q <= '0;
									quo_q <= '0;
									it_q <= 7'd64;
									state_q <= S_DIV;
								end
							end
							// The Canberra sum is passed through as a two's complement
							// value sign-extended to the output width.
							MET_CANBERRA: dist_q <= 60'(main_q);
							default: ;
						endcase
					end
				end
				S_RTA: begin
					// Digit-by-digit square root, one digit pair per cycle.
					rt_v_q <= {rt_v_q[93:0], 2'b00};
					if (rt_rem_n >= rt_t) begin
						rt_rem_q <= rt_rem_n - rt_t;
						rt_r_q <= {rt_r_q[62:0], 1'b1};
					end else begin
						rt_rem_q <= rt_rem_n;
						rt_r_q <= {rt_r_q[62:0], 1'b0};
					end
					it_q <= it_q - 1'b1;
					if (it_q == 7'd1) state_q <= S_RTB;
				end
				S_RTB: begin
					if (div_kind_q == 3'd0) begin
						dist_q <= rt_r_q[59:0];
						state_q <= S_OUT;
					end else if (div_kind_q == 3'd1) begin
						ra_q <= rt_r_q[31:0];
						rt_v_q <= {23'd0, nb_q, 32'd0};
						rt_r_q <= '0;
						rt_rem_q <= '0;
						it_q <= 7'd32;
						div_kind_q <= 3'd2;
						state_q <= S_RTA;
					end else state_q <= S_MUL;
				end
				S_MUL: begin
					den_q <= 48'(ra_q[20:0]) * 48'(rt_r_q[20:0]);
					state_q <= S_COS;
				end
				S_COS: begin
					if (den_q == '0) begin
						st_q <= ST_ZERO_DIV;
						state_q <= S_OUT;
					end else if ($signed({2'b00, den_q}) <= $signed(50'(main_q))) begin
						state_q <= S_OUT;
					end else if (($signed({2'b00, den_q}) - $signed(50'(main_q))) >=
						$signed({1'b0, den_q, 1'b0})) begin
						dist_q <= 60'd131072;
						state_q <= S_OUT;
					end else begin
						n_q <= 64'($signed({2'b00, den_q}) - $signed(50'(main_q)));
						dv_q <= den_q;
						rem_q <= '0;
						quo_q <= '0;
						it_q <= 7'd64;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					n_q <= {n_q[62:0], 1'b0};
					if (div_rem_n >= 64'(dv_q)) begin
						rem_q <= div_rem_n - 64'(dv_q);
						quo_q <= {quo_q[62:0], 1'b1};
					end else begin
						rem_q <= div_rem_n;
						quo_q <= {quo_q[62:0], 1'b0};
					end
					it_q <= it_q - 1'b1;
					if (it_q == 7'd1) state_q <= S_DIVEND;
				end
				S_DIVEND: begin
					// Fraction: 16 more bits from the remainder.
					if (it_q == 7'd0) begin
						n_q <= '0;
						it_q <= 7'd16;
						state_q <= S_DIVEND;
						if (quo_q > 64'(DIST_MAX >> 16)) begin
							dist_q <= DIST_MAX;
							state_q <= S_OUT;
						end else dist_q <= quo_q[59:0];
					end else begin
						if (div_rem_n >= 64'(dv_q)) begin
							rem_q <= div_rem_n - 64'(dv_q);
							dist_q <= {dist_q[58:0], 1'b1};
						end else begin
							rem_q <= div_rem_n;
							dist_q <= {dist_q[58:0], 1'b0};
						end
						it_q <= it_q - 1'b1;
						if (it_q == 7'd1) state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid || !out_stall) begin
						out_valid <= 1'b1;
						main_q <= '0;
						na_q <= '0;
						nb_q <= '0;
						largest_q <= '0;
						ovf_q <= 1'b0;
						state_q <= S_ACC;
					end
				end
				default: state_q <= S_ACC;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> hdl/vector_distance_engine_core.sv
`timescale 1ns / 1ps
`default_nettype none
// A non-last item is summed in the back end; a Canberra item also runs through
// the shared bit-serial divider. A last item then adds the finish steps
// (cosine: two 32-step roots, a multiply and an 80-step division).
// The front end takes one item per cycle into a four-entry queue, unless it is full.
// Reset (arst_n low) clears all sums, the queue and selects Euclidean.
module vector_distance_engine_core #(
	parameter int unsigned MAX_LEN = vde_pkg::MAX_LEN_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_stall,
	input  wire signed [15:0] elem_a,
	input  wire signed [15:0] elem_b,
	input  wire               last_pair,
	output logic              out_valid,
	input  wire               out_stall,
	output logic [59:0]       distance,
	output logic [1:0]        status,
	input  wire               psel,
	input  wire               penable,
	input  wire               pwrite,
	input  wire [1:0]         paddr,
	input  wire [31:0]        pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import vde_pkg::*;

	metric_t metric_q;
	logic fq_valid, fq_stall, bq_valid, bq_stall;
	pair_t fq_data, bq_data;

	// The single metric register sits at byte address zero.
	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {29'd0, metric_q} : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) metric_q <= MET_EUCLID;
		else if (psel && penable && pwrite && paddr == 2'd0)
			metric_q <= metric_t'(pwdata[2:0]);
	end

	vde_front #(.MAX_LEN(MAX_LEN)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .elem_a, .elem_b, .last_pair,
		.metric(metric_q), .q_valid(fq_valid), .q_stall(fq_stall), .q_data(fq_data)
	);

	vde_fifo u_fifo (
		.clk, .arst_n, .in_valid(fq_valid), .in_stall(fq_stall), .in_data(fq_data),
		.out_valid(bq_valid), .out_stall(bq_stall), .out_data(bq_data)
	);

	vde_back u_back (
		.clk, .arst_n, .in_valid(bq_valid), .in_stall(bq_stall), .in_data(bq_data),
		.out_valid, .out_stall, .distance, .status
	);
endmodule
`default_nettype wire
